>>> hw/rtl/rsa_pkg.sv
// Shared types and codes for the region sector allocator.
`default_nettype none
package rsa_pkg;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_TOO_LARGE = 2'd2;
    localparam logic [1:0] STAT_NO_SPACE  = 2'd3;

    // Header bytes counted in front of every payload
    localparam int HEADER_BYTES = 5;
    localparam int SLOT_COUNT   = 1024;
    localparam int SLOT_AW      = 10;
    localparam int COUNT_W      = 8;
    localparam int LEN_W        = 20;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_MARK,
        S_SCAN,
        S_DONE
    } state_t;

    // Where the sequencer goes once a run has been marked
    typedef enum logic {
        MN_SCAN,
        MN_DONE
    } mark_next_t;

endpackage
`default_nettype wire

>>> hw/rtl/region_sector_allocator_top.sv
// Top level of the region sector allocator: sequencer around slot table and free map.
`default_nettype none
// Region sector allocator. A transaction is taken when start is high and busy
// is low; its result appears for exactly one cycle with done high and cannot
// be held off. A read goes through S_LOOKUP to S_DONE, and so does a write whose
// size is rejected or unchanged. Any other write releases the old run, scans
// the free map (one free-map bit per cycle, at most store_end sectors) and
// marks the new run used (or, with no room, the old run again), so the time
// grows with the store size and is set by the single read port of the
// free-map RAM. After reset the slot table is swept to zero, one entry per
// cycle, and busy stays high until the sweep is complete.
module region_sector_allocator_top #(
    parameter int STORE_SECTORS = 4096,
    parameter int SECTOR_BYTES  = 4096,
    parameter int MAX_RUN       = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [4:0]  slot_x,
    input  wire logic [4:0]  slot_z,
    input  wire logic [19:0] payload_length,
    output logic             done,
    output logic [1:0]       status,
    output logic [11:0]      sector_start,
    output logic [7:0]       sector_count,
    output logic [9:0]       slot_index,
    output logic             table_changed,
    output logic [7:0]       grown_sectors
);
    import rsa_pkg::*;

    localparam int SECW = (STORE_SECTORS > 1) ? $clog2(STORE_SECTORS) : 1;
    localparam int EW   = $clog2(STORE_SECTORS + 1);
    localparam int MW   = ((EW > COUNT_W) ? EW : COUNT_W) + 1;
    localparam int NW   = LEN_W + 1;
    localparam int SW   = SECW + COUNT_W;

    state_t                 state_reg, state_next;
    logic [SLOT_AW-1:0]     idx_reg, idx_next;
    logic                   op_reg, op_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [COUNT_W-1:0]     need_reg, need_next;
    logic                   present_reg, present_next;
    logic [EW-1:0]          old_start_reg, old_start_next;
    logic [COUNT_W-1:0]     old_cnt_reg, old_cnt_next;
    logic [EW-1:0]          scan_addr_reg, scan_addr_next;
    logic                   rdv_reg, rdv_next;
    logic [EW-1:0]          rpos_reg, rpos_next;
    logic [COUNT_W-1:0]     run_len_reg, run_len_next;
    logic [EW-1:0]          run_start_reg, run_start_next;
    logic [EW-1:0]          mark_base_reg, mark_base_next;
    logic [COUNT_W-1:0]     mark_len_reg, mark_len_next;
    logic                   mark_val_reg, mark_val_next;
    mark_next_t             mark_nx_reg, mark_nx_next;
    logic [COUNT_W-1:0]     mark_i_reg, mark_i_next;
    logic [EW-1:0]          store_end_reg, store_end_next;
    logic [SLOT_AW-1:0]     clr_reg, clr_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [EW-1:0]          res_start_reg, res_start_next;
    logic [COUNT_W-1:0]     res_count_reg, res_count_next;
    logic                   res_changed_reg, res_changed_next;
    logic [COUNT_W-1:0]     res_grown_reg, res_grown_next;
    logic                   commit_reg, commit_next;

    // Memory ports
    logic                   st_we, st_re;
    logic [SLOT_AW-1:0]     st_waddr, st_raddr;
    logic [SW-1:0]          st_wdata, st_rdata;
    logic                   fm_we, fm_re;
    logic [SECW-1:0]        fm_waddr, fm_raddr;
    logic [0:0]             fm_wdata, fm_rdata;

    // Helpers
    logic [NW-1:0]          need_w;
    logic [COUNT_W-1:0]     rd_cnt;
    logic [MW-1:0]          mark_sum;
    logic [EW:0]            grow_end;
    logic                   issue;
    logic [COUNT_W-1:0]     run_inc;

    rsa_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    rsa_ram #(.WIDTH(1), .DEPTH(STORE_SECTORS)) u_free_ram (
        .clk   (clk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .re    (fm_re),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    // Sector count including header, and other datapath helpers
    assign need_w   = (NW'(len_reg) + NW'(HEADER_BYTES)) / NW'(SECTOR_BYTES) + NW'(1);
    assign rd_cnt   = st_rdata[COUNT_W-1:0];
    assign mark_sum = MW'(mark_base_reg) + MW'(mark_i_reg);
    assign grow_end = (EW+1)'(store_end_reg) + (EW+1)'(need_reg);
    assign issue    = (state_reg == S_SCAN) && (scan_addr_reg < store_end_reg);
    assign run_inc  = run_len_reg + COUNT_W'(1);

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            idx_reg         <= '0;
            op_reg          <= 1'b0;
            len_reg         <= '0;
            need_reg        <= '0;
            present_reg     <= 1'b0;
            old_start_reg   <= '0;
            old_cnt_reg     <= '0;
            scan_addr_reg   <= '0;
            rdv_reg         <= 1'b0;
            rpos_reg        <= '0;
            run_len_reg     <= '0;
            run_start_reg   <= '0;
            mark_base_reg   <= '0;
            mark_len_reg    <= '0;
            mark_val_reg    <= 1'b0;
            mark_nx_reg     <= MN_DONE;
            mark_i_reg      <= '0;
            store_end_reg   <= EW'(1);
            clr_reg         <= '0;
            res_status_reg  <= STAT_OK;
            res_start_reg   <= '0;
            res_count_reg   <= '0;
            res_changed_reg <= 1'b0;
            res_grown_reg   <= '0;
            commit_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            op_reg          <= op_next;
            len_reg         <= len_next;
            need_reg        <= need_next;
            present_reg     <= present_next;
            old_start_reg   <= old_start_next;
            old_cnt_reg     <= old_cnt_next;
            scan_addr_reg   <= scan_addr_next;
            rdv_reg         <= rdv_next;
            rpos_reg        <= rpos_next;
            run_len_reg     <= run_len_next;
            run_start_reg   <= run_start_next;
            mark_base_reg   <= mark_base_next;
            mark_len_reg    <= mark_len_next;
            mark_val_reg    <= mark_val_next;
            mark_nx_reg     <= mark_nx_next;
            mark_i_reg      <= mark_i_next;
            store_end_reg   <= store_end_next;
            clr_reg         <= clr_next;
            res_status_reg  <= res_status_next;
            res_start_reg   <= res_start_next;
            res_count_reg   <= res_count_next;
            res_changed_reg <= res_changed_next;
            res_grown_reg   <= res_grown_next;
            commit_reg      <= commit_next;
        end
    end

    // Sequencer: next state, memory controls and result setup
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        op_next          = op_reg;
        len_next         = len_reg;
        need_next        = need_reg;
        present_next     = present_reg;
        old_start_next   = old_start_reg;
        old_cnt_next     = old_cnt_reg;
        scan_addr_next   = scan_addr_reg;
        rdv_next         = 1'b0;
        rpos_next        = rpos_reg;
        run_len_next     = run_len_reg;
        run_start_next   = run_start_reg;
        mark_base_next   = mark_base_reg;
        mark_len_next    = mark_len_reg;
        mark_val_next    = mark_val_reg;
        mark_nx_next     = mark_nx_reg;
        mark_i_next      = mark_i_reg;
        store_end_next   = store_end_reg;
        clr_next         = clr_reg;
        res_status_next  = res_status_reg;
        res_start_next   = res_start_reg;
        res_count_next   = res_count_reg;
        res_changed_next = res_changed_reg;
        res_grown_next   = res_grown_reg;
        commit_next      = commit_reg;

        st_we    = 1'b0;
        st_waddr = idx_reg;
        st_wdata = {SECW'(res_start_reg), res_count_reg};
        st_re    = 1'b0;
        st_raddr = {slot_z, slot_x};
        fm_we    = 1'b0;
        fm_waddr = mark_sum[SECW-1:0];
        fm_wdata = mark_val_reg;
        fm_re    = issue;
        fm_raddr = scan_addr_reg[SECW-1:0];

        case (state_reg)
            // Sweep the slot table to empty after reset
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = '0;
                clr_next = clr_reg + SLOT_AW'(1);
                if (clr_reg == SLOT_AW'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    st_re      = 1'b1;
                    idx_next   = {slot_z, slot_x};
                    op_next    = operation;
                    len_next   = payload_length;
                    state_next = S_LOOKUP;
                end
            end

            // Slot entry is on the read port; decide the path
            S_LOOKUP:
            begin
                old_start_next   = EW'(st_rdata[SW-1:COUNT_W]);
                old_cnt_next     = rd_cnt;
                present_next     = (rd_cnt != '0);
                need_next        = need_w[COUNT_W-1:0];
                res_changed_next = 1'b0;
                res_grown_next   = '0;
                commit_next      = 1'b0;
                res_status_next  = STAT_OK;
                res_start_next   = EW'(st_rdata[SW-1:COUNT_W]);
                res_count_next   = rd_cnt;
                state_next       = S_DONE;
                if (!op_reg)
                begin
                    if (rd_cnt == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                end
                else if (need_w > NW'(MAX_RUN))
                begin
                    res_status_next = STAT_TOO_LARGE;
                    res_start_next  = '0;
                    res_count_next  = '0;
                end
                else if ((rd_cnt != '0) && (NW'(rd_cnt) == need_w))
                begin
                    // Same size: keep the current placement
                end
                else
                begin
                    scan_addr_next = EW'(1);
                    run_len_next   = '0;
                    if (rd_cnt != '0)
                    begin
                        // Release the old run before searching
                        mark_base_next = EW'(st_rdata[SW-1:COUNT_W]);
                        mark_len_next  = rd_cnt;
                        mark_val_next  = 1'b1;
                        mark_nx_next   = MN_SCAN;
                        mark_i_next    = '0;
                        state_next     = S_MARK;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // Write one free-map bit per cycle, clipped at the store end
            S_MARK:
            begin
                fm_we       = (mark_sum < MW'(store_end_reg));
                mark_i_next = mark_i_reg + COUNT_W'(1);
                if (mark_i_reg == mark_len_reg - COUNT_W'(1))
                begin
                    if (mark_nx_reg == MN_SCAN)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // First-fit search, one sector per cycle; with no fit, append at the store end or fail
            S_SCAN:
            begin
                scan_addr_next = scan_addr_reg + EW'(issue);
                rdv_next       = issue;
                rpos_next      = scan_addr_reg;
                if (rdv_reg)
                begin
                    if (fm_rdata[0])
                    begin
                        run_len_next = run_inc;
                        if (run_len_reg == '0)
                        begin
                            run_start_next = rpos_reg;
                        end
                        if (run_inc == need_reg)
                        begin
                            mark_base_next   = (run_len_reg == '0) ? rpos_reg : run_start_reg;
                            mark_len_next    = need_reg;
                            mark_val_next    = 1'b0;
                            mark_nx_next     = MN_DONE;
                            mark_i_next      = '0;
                            res_status_next  = STAT_OK;
                            res_start_next   = (run_len_reg == '0) ? rpos_reg : run_start_reg;
                            res_count_next   = need_reg;
                            res_changed_next = 1'b1;
                            res_grown_next   = '0;
                            commit_next      = 1'b1;
                            state_next       = S_MARK;
                        end
                    end
                    else
                    begin
                        run_len_next = '0;
                    end
                end
                else if (!issue)
                begin
                    if (grow_end > (EW+1)'(STORE_SECTORS))
                    begin
                        // No room: restore the old run as used
                        res_status_next  = STAT_NO_SPACE;
                        res_start_next   = '0;
                        res_count_next   = '0;
                        res_changed_next = 1'b0;
                        res_grown_next   = '0;
                        commit_next      = 1'b0;
                        mark_base_next   = old_start_reg;
                        mark_len_next    = old_cnt_reg;
                        mark_val_next    = 1'b0;
                        mark_nx_next     = MN_DONE;
                        mark_i_next      = '0;
                        state_next       = present_reg ? S_MARK : S_DONE;
                    end
                    else
                    begin
                        // Append at the store end
                        store_end_next   = grow_end[EW-1:0];
                        mark_base_next   = store_end_reg;
                        mark_len_next    = need_reg;
                        mark_val_next    = 1'b0;
                        mark_nx_next     = MN_DONE;
                        mark_i_next      = '0;
                        res_status_next  = STAT_OK;
                        res_start_next   = store_end_reg;
                        res_count_next   = need_reg;
                        res_changed_next = 1'b1;
                        res_grown_next   = need_reg;
                        commit_next      = 1'b1;
                        state_next       = S_MARK;
                    end
                end
            end

            // Present the result and, on a commit, store the new placement
            S_DONE:
            begin
                st_we      = commit_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign status        = res_status_reg;
    assign sector_start  = 12'(res_start_reg);
    assign sector_count  = res_count_reg;
    assign slot_index    = idx_reg;
    assign table_changed = res_changed_reg;
    assign grown_sectors = res_grown_reg;

    // Checks
    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (EW+1)'(store_end_reg) <= (EW+1)'(STORE_SECTORS))
        else $error("store end beyond capacity");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_NO_SPACE || status == STAT_TOO_LARGE))
        |-> (!table_changed && grown_sectors == '0 && sector_count == '0))
        else $error("failed write reports a placement");

    a_grow_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && grown_sectors != '0) |-> (table_changed && sector_count == grown_sectors))
        else $error("grown sectors disagree with count");

    a_changed_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_changed) |-> (sector_count != '0 && status == STAT_OK))
        else $error("new placement with zero count");

endmodule
`default_nettype wire

>>> hw/rtl/rsa_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module rsa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data updated when re is high
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire
